### design/phi4_pkg.sv
// Shared types and constants for the phi^4 free energy site kernel.
package phi4_pkg;

    localparam int FRAC_BITS = 28;
    localparam int FIELD_W   = 32;

    typedef logic signed [FIELD_W-1:0] fix_t;

    typedef enum logic [1:0] {
        REG_COEF_A     = 2'd0,
        REG_COEF_B     = 2'd1,
        REG_COEF_KAPPA = 2'd2
    } reg_idx_t;

    localparam fix_t COEF_A_RST     = -32'sd838861;
    localparam fix_t COEF_B_RST     = 32'sd838861;
    localparam fix_t COEF_KAPPA_RST = 32'sd536871;

    typedef struct packed {
        fix_t order_value;
        fix_t grad_x;
        fix_t grad_y;
        fix_t grad_z;
        fix_t laplacian;
    } site_t;

    typedef struct packed {
        fix_t energy_density;
        fix_t chem_potential;
        fix_t stress_xx;
        fix_t stress_xy;
        fix_t stress_xz;
        fix_t stress_yy;
        fix_t stress_yz;
        fix_t stress_zz;
    } result_t;

    typedef struct packed {
        fix_t phi;
        fix_t p2;
        fix_t gg0;
        fix_t gg1;
        fix_t gg2;
        fix_t gxy;
        fix_t gxz;
        fix_t gyz;
        fix_t phil;
        fix_t aphi;
        fix_t klap;
    } stage2_t;

    typedef struct packed {
        fix_t p2;
        fix_t p3;
        fix_t p4;
        fix_t g2;
        fix_t bp2;
        fix_t ap2;
        fix_t kphil;
        fix_t kgg0;
        fix_t kgg1;
        fix_t kgg2;
        fix_t kxy;
        fix_t kxz;
        fix_t kyz;
        fix_t aphi;
        fix_t klap;
    } stage3_t;

    typedef struct packed {
        fix_t p2;
        fix_t kg2h;
        fix_t bp3;
        fix_t bp4;
        fix_t fed1;
        fix_t ap2;
        fix_t kphil;
        fix_t kgg0;
        fix_t kgg1;
        fix_t kgg2;
        fix_t kxy;
        fix_t kxz;
        fix_t kyz;
        fix_t aphi;
        fix_t klap;
    } stage4_t;

    typedef struct packed {
        fix_t fed;
        fix_t mu;
        fix_t p0;
        fix_t kgg0;
        fix_t kgg1;
        fix_t kgg2;
        fix_t kxy;
        fix_t kxz;
        fix_t kyz;
    } stage5_t;

endpackage

### design/phi4_free_energy_site_kernel.sv
// Symmetric phi^4 free energy, chemical potential and stress per lattice site.
//
// Usage:
//   site channel (site_valid/site_ready/site): one request per lattice site
//   with phi, its gradient and its Laplacian, all signed Q3.28.
//   result channel (result_valid/result_ready/result): energy density,
//   chemical potential and the six distinct stress entries, saturated.
//   cfg port (cfg_we/cfg_index/cfg_data): writes coef_a, coef_b, coef_kappa;
//   write only while no request is in flight.
// Pipeline: six register stages (s1, s2, s3, s4, s5, result),
//   with at most one multiplier level each.
// Throughput: one request per cycle, sustained unless a stall holds the pipeline.
// Reset: pipeline empties, coefficients return to their reset values.
// Stall: when result is held and result_ready is low, the whole pipeline
//   freezes and site_ready drops; nothing is dropped or repeated.
module phi4_free_energy_site_kernel #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [1:0]             cfg_index,
    input  logic [31:0]            cfg_data,
    input  logic                   site_valid,
    output logic                   site_ready,
    input  phi4_pkg::site_t        site,
    output logic                   result_valid,
    input  logic                   result_ready,
    output phi4_pkg::result_t      result
);
    import phi4_pkg::*;

    localparam int EFF_W = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
    localparam logic signed [65:0] SAT_HI = (66'sd1 <<< (EFF_W - 1)) - 66'sd1;
    localparam logic signed [65:0] SAT_LO = -SAT_HI - 66'sd1;
    localparam int STAGES = 6;

    function automatic fix_t sat(input logic signed [65:0] v);
        if (v > SAT_HI)
            return SAT_HI[31:0];
        if (v < SAT_LO)
            return SAT_LO[31:0];
        return v[31:0];
    endfunction

    function automatic fix_t fmul(input fix_t x, input fix_t y);
        logic signed [63:0] prod;
        prod = x * y;
        return sat(66'(prod >>> FRAC_BITS));
    endfunction

    fix_t coef_a_reg, coef_b_reg, coef_kappa_reg;

    logic [STAGES-1:0] vld_reg, vld_next;
    logic              adv;

    site_t   s1_reg, s1_next;
    stage2_t s2_reg, s2_next;
    stage3_t s3_reg, s3_next;
    stage4_t s4_reg, s4_next;
    stage5_t s5_reg, s5_next;
    result_t res_reg, res_next;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_a_reg     <= COEF_A_RST;
            coef_b_reg     <= COEF_B_RST;
            coef_kappa_reg <= COEF_KAPPA_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_COEF_A:     coef_a_reg     <= sat(66'(signed'(cfg_data)));
                REG_COEF_B:     coef_b_reg     <= sat(66'(signed'(cfg_data)));
                REG_COEF_KAPPA: coef_kappa_reg <= sat(66'(signed'(cfg_data)));
                default:        ;
            endcase
        end
    end

    assign adv          = !vld_reg[STAGES-1] || result_ready;
    assign site_ready   = adv;
    assign result_valid = vld_reg[STAGES-1];
    assign result       = res_reg;
    assign vld_next     = {vld_reg[STAGES-2:0], site_valid};

    // stage 1: clamp inputs to the working range
    always_comb
    begin
        s1_next.order_value = sat(66'(site.order_value));
        s1_next.grad_x      = sat(66'(site.grad_x));
        s1_next.grad_y      = sat(66'(site.grad_y));
        s1_next.grad_z      = sat(66'(site.grad_z));
        s1_next.laplacian   = sat(66'(site.laplacian));
    end

    // stage 2: first-level products
    always_comb
    begin
        s2_next.phi  = s1_reg.order_value;
        s2_next.p2   = fmul(s1_reg.order_value, s1_reg.order_value);
        s2_next.gg0  = fmul(s1_reg.grad_x, s1_reg.grad_x);
        s2_next.gg1  = fmul(s1_reg.grad_y, s1_reg.grad_y);
        s2_next.gg2  = fmul(s1_reg.grad_z, s1_reg.grad_z);
        s2_next.gxy  = fmul(s1_reg.grad_x, s1_reg.grad_y);
        s2_next.gxz  = fmul(s1_reg.grad_x, s1_reg.grad_z);
        s2_next.gyz  = fmul(s1_reg.grad_y, s1_reg.grad_z);
        s2_next.phil = fmul(s1_reg.order_value, s1_reg.laplacian);
        s2_next.aphi = fmul(coef_a_reg, s1_reg.order_value);
        s2_next.klap = fmul(coef_kappa_reg, s1_reg.laplacian);
    end

    // stage 3: powers of phi, |g|^2, coefficient-scaled p2 and phi*laplacian, kappa-scaled gradient products
    always_comb
    begin
        s3_next.p2    = s2_reg.p2;
        s3_next.p3    = fmul(s2_reg.p2, s2_reg.phi);
        s3_next.p4    = fmul(s2_reg.p2, s2_reg.p2);
        s3_next.g2    = sat(66'(s2_reg.gg0) + 66'(s2_reg.gg1) + 66'(s2_reg.gg2));
        s3_next.bp2   = fmul(coef_b_reg, s2_reg.p2);
        s3_next.ap2   = fmul(coef_a_reg, s2_reg.p2);
        s3_next.kphil = fmul(coef_kappa_reg, s2_reg.phil);
        s3_next.kgg0  = fmul(coef_kappa_reg, s2_reg.gg0);
        s3_next.kgg1  = fmul(coef_kappa_reg, s2_reg.gg1);
        s3_next.kgg2  = fmul(coef_kappa_reg, s2_reg.gg2);
        s3_next.kxy   = fmul(coef_kappa_reg, s2_reg.gxy);
        s3_next.kxz   = fmul(coef_kappa_reg, s2_reg.gxz);
        s3_next.kyz   = fmul(coef_kappa_reg, s2_reg.gyz);
        s3_next.aphi  = s2_reg.aphi;
        s3_next.klap  = s2_reg.klap;
    end

    // stage 4
    always_comb
    begin
        s4_next.p2    = s3_reg.p2;
        s4_next.kg2h  = fmul(coef_kappa_reg, s3_reg.g2) >>> 1;
        s4_next.bp3   = fmul(coef_b_reg, s3_reg.p3);
        s4_next.bp4   = fmul(coef_b_reg, s3_reg.p4);
        s4_next.fed1  = sat(66'(coef_a_reg >>> 1) + 66'(s3_reg.bp2 >>> 2));
        s4_next.ap2   = s3_reg.ap2;
        s4_next.kphil = s3_reg.kphil;
        s4_next.kgg0  = s3_reg.kgg0;
        s4_next.kgg1  = s3_reg.kgg1;
        s4_next.kgg2  = s3_reg.kgg2;
        s4_next.kxy   = s3_reg.kxy;
        s4_next.kxz   = s3_reg.kxz;
        s4_next.kyz   = s3_reg.kyz;
        s4_next.aphi  = s3_reg.aphi;
        s4_next.klap  = s3_reg.klap;
    end

    // stage 5: energy, potential, isotropic pressure
    always_comb
    begin
        s5_next.fed  = sat(66'(fmul(s4_reg.fed1, s4_reg.p2)) + 66'(s4_reg.kg2h));
        s5_next.mu   = sat(66'(s4_reg.aphi) + 66'(s4_reg.bp3) - 66'(s4_reg.klap));
        s5_next.p0   = sat(66'(s4_reg.ap2 >>> 1)
                           + ((66'(s4_reg.bp4) * 66'sd3) >>> 2)
                           - 66'(s4_reg.kphil)
                           - 66'(s4_reg.kg2h));
        s5_next.kgg0 = s4_reg.kgg0;
        s5_next.kgg1 = s4_reg.kgg1;
        s5_next.kgg2 = s4_reg.kgg2;
        s5_next.kxy  = s4_reg.kxy;
        s5_next.kxz  = s4_reg.kxz;
        s5_next.kyz  = s4_reg.kyz;
    end

    // stage 6: stress diagonal; off-diagonal entries, energy and potential pass through
    always_comb
    begin
        res_next.energy_density = s5_reg.fed;
        res_next.chem_potential = s5_reg.mu;
        res_next.stress_xx      = sat(66'(s5_reg.p0) + 66'(s5_reg.kgg0));
        res_next.stress_xy      = s5_reg.kxy;
        res_next.stress_xz      = s5_reg.kxz;
        res_next.stress_yy      = sat(66'(s5_reg.p0) + 66'(s5_reg.kgg1));
        res_next.stress_yz      = s5_reg.kyz;
        res_next.stress_zz      = sat(66'(s5_reg.p0) + 66'(s5_reg.kgg2));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg  <= s1_next;
            s2_reg  <= s2_next;
            s3_reg  <= s3_next;
            s4_reg  <= s4_next;
            s5_reg  <= s5_next;
            res_reg <= res_next;
        end
    end

    // a stalled pipeline keeps every valid bit
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !site_ready |=> $stable(vld_reg))
        else $error("valid bits moved during stall");

    // an accepted request enters stage 1
    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        site_valid && site_ready |=> vld_reg[0])
        else $error("accepted request lost at stage 1");

    // a request in the last internal stage reaches the output when not stalled
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[STAGES-2] && site_ready |=> result_valid)
        else $error("request lost before output");

    // full-width coefficient writes land unchanged
    a_cfg_a: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we && (cfg_index == REG_COEF_A) && (EFF_W == 32)
        |=> coef_a_reg == $past(cfg_data))
        else $error("coef_a write mismatch");

endmodule
